/* sv/stdds_pkg.sv */
// ----------------------------------------------------------------------------
// Stereo triangle DDS package
// Shared sizes, derived constants, register indexes and the control
// structures passed between the top level, the lanes and their dividers.
// ----------------------------------------------------------------------------
package stdds_pkg;

    localparam int TABLE_ENTRIES = 256;

    localparam int INC_W     = 24;
    localparam int SMP_W     = 16;
    localparam int CFG_IDX_W = 8;

    // A remainder below TABLE_ENTRIES, and that remainder with one more bit.
    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int REM_W = IDX_W + 1;

    // Twice the phase span divided by the table size is always 2^17.
    localparam int Q_W = 17;

    // Dividend of the increment division: twice the increment.
    localparam int DVD_W = INC_W + 1;

    // Reciprocal of the table size, exact for every dividend below 2^DVD_W.
    localparam int RECIP_SHIFT = DVD_W + IDX_W;
    localparam int RECIP_W     = DVD_W + 1;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((longint'(1) << RECIP_SHIFT) + longint'(TABLE_ENTRIES) - 1)
                 / longint'(TABLE_ENTRIES));

    localparam logic [REM_W-1:0] N_VAL = REM_W'(TABLE_ENTRIES);

    // Boundaries on twice the phase, kept as quotient and remainder by N.
    localparam longint FALL_BOUND = longint'(131072) * longint'((TABLE_ENTRIES + 1) / 2);
    localparam longint FLAT_BOUND = longint'(65536) * longint'(TABLE_ENTRIES - 1);

    localparam logic [Q_W-1:0]   FALL_Q = Q_W'(FALL_BOUND / TABLE_ENTRIES);
    localparam logic [IDX_W-1:0] FALL_R = IDX_W'(FALL_BOUND % TABLE_ENTRIES);
    localparam logic [Q_W-1:0]   FLAT_Q = Q_W'(FLAT_BOUND / TABLE_ENTRIES);
    localparam logic [IDX_W-1:0] FLAT_R = IDX_W'(FLAT_BOUND % TABLE_ENTRIES);

    localparam bit ODD_SIZE = (TABLE_ENTRIES % 2) == 1;

    // Output of the level segment at the peak of an odd-sized table.
    localparam logic signed [SMP_W-1:0] FLAT_LEVEL = SMP_W'(32767 - 65536 / TABLE_ENTRIES);

    localparam logic [CFG_IDX_W-1:0] REG_LEFT_INC  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_INC = CFG_IDX_W'(1);

    typedef struct packed {
        logic             step;
        logic             restart;
        logic             cfg_wr;
        logic [INC_W-1:0] cfg_data;
    } t_lane_ctl;

    typedef struct packed {
        logic             busy;
        logic [Q_W-1:0]   quo;
        logic [IDX_W-1:0] rem;
    } t_inc_step;

endpackage

/* sv/stdds_smp_in_if.sv */
// ----------------------------------------------------------------------------
// Sample tick request channel
// Carries the restart and buffer-end marks of one sample tick.
// ----------------------------------------------------------------------------
interface stdds_smp_in_if import stdds_pkg::*; ();

    logic valid;
    logic ready;
    logic restart;
    logic block_last;

    modport source (output valid, output restart, output block_last, input ready);
    modport sink (input valid, input restart, input block_last, output ready);

endinterface

/* sv/stdds_smp_out_if.sv */
// ----------------------------------------------------------------------------
// Sample pair result channel
// Carries one left and right sample and the buffer-end mark.
// ----------------------------------------------------------------------------
interface stdds_smp_out_if import stdds_pkg::*; ();

    logic                    valid;
    logic                    ready;
    logic signed [SMP_W-1:0] left_sample;
    logic signed [SMP_W-1:0] right_sample;
    logic                    buffer_done;

    modport source (output valid, output left_sample, output right_sample,
                    output buffer_done, input ready);
    modport sink (input valid, input left_sample, input right_sample,
                  input buffer_done, output ready);

endinterface

/* sv/stdds_cfg_if.sv */
// ----------------------------------------------------------------------------
// Configuration write channel
// Carries a register index and the data written to it.
// ----------------------------------------------------------------------------
interface stdds_cfg_if import stdds_pkg::*; ();

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [INC_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);

endinterface

/* sv/stdds_inc_div.sv */
// ----------------------------------------------------------------------------
// Increment divider
// Splits twice a phase increment into quotient and remainder by the table
// size with a reciprocal multiplication: first the quotient, then the
// remainder. The quotient is kept modulo 2^17.
// ----------------------------------------------------------------------------
module stdds_inc_div import stdds_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [INC_W-1:0] i_inc,
    output t_inc_step        o_step
);

    localparam int PROD_W = DVD_W + RECIP_W;

    logic             r_busy;
    logic             r_ph;
    logic [DVD_W-1:0] r_dvd;
    logic [IDX_W-1:0] r_rem;
    logic [Q_W-1:0]   r_quo;

    logic [PROD_W-1:0] prod;
    logic [Q_W-1:0]    n_quo;
    logic [IDX_W-1:0]  n_rem;

    // The remainder only needs the low bits of the quotient, since it is
    // known to lie below the table size.
    always_comb begin
        prod  = PROD_W'(r_dvd) * PROD_W'(RECIP);
        n_quo = Q_W'(prod >> RECIP_SHIFT);
        n_rem = r_dvd[IDX_W-1:0] - IDX_W'(r_quo[IDX_W-1:0] * N_VAL);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ph   <= 1'b0;
            r_rem  <= '0;
            r_quo  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_ph   <= 1'b0;
        end else if (r_busy) begin
            if (!r_ph) begin
                r_quo <= n_quo;
                r_ph  <= 1'b1;
            end else begin
                r_rem  <= n_rem;
                r_ph   <= 1'b0;
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= {i_inc, 1'b0};
        end
    end

    assign o_step = '{busy: r_busy, quo: r_quo, rem: r_rem};

endmodule

/* sv/stdds_lane.sv */
// ----------------------------------------------------------------------------
// Channel lane
// Phase accumulator and triangle interpolation of one channel. The phase is
// held as twice its value divided by the table size (quotient and remainder),
// from which the interpolated, truncated sample follows with adds only.
// ----------------------------------------------------------------------------
module stdds_lane import stdds_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_lane_ctl               i_ctl,
    output logic                    o_busy,
    output logic signed [SMP_W-1:0] o_sample
);

    localparam int V_W = Q_W + 2;

    localparam logic signed [V_W-1:0] HALF_SCALE = V_W'(32768);
    localparam logic signed [V_W-1:0] FALL_OFS   = V_W'(98304);
    localparam logic signed [V_W-1:0] SAT_HI     = V_W'(32767);
    localparam logic signed [V_W-1:0] SAT_LO     = V_W'(-32768);

    t_inc_step inc;

    stdds_inc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_ctl.cfg_wr),
        .i_inc   (i_ctl.cfg_data),
        .o_step  (inc)
    );

    logic [Q_W-1:0]   r_q;
    logic [IDX_W-1:0] r_r;

    logic [Q_W-1:0]   base_q;
    logic [IDX_W-1:0] base_r;
    logic [REM_W-1:0] sum_r;
    logic             carry;
    logic [Q_W-1:0]   n_q;
    logic [IDX_W-1:0] n_r;

    always_comb begin
        base_q = i_ctl.restart ? '0 : r_q;
        base_r = i_ctl.restart ? '0 : r_r;
        sum_r  = {1'b0, base_r} + {1'b0, inc.rem};
        carry  = sum_r >= N_VAL;
        n_r    = carry ? IDX_W'(sum_r - N_VAL) : sum_r[IDX_W-1:0];
        n_q    = base_q + inc.quo + Q_W'(carry);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
            r_r <= '0;
        end else if (i_ctl.step) begin
            r_q <= n_q;
            r_r <= n_r;
        end
    end

    logic                  at_fall;
    logic                  at_flat;
    logic                  frac_nz;
    logic signed [V_W-1:0] q_s;
    logic signed [V_W-1:0] rise;
    logic signed [V_W-1:0] fall_base;
    logic signed [V_W-1:0] fall;
    logic signed [V_W-1:0] level;

    // The rising part is 2P/N - 32768 and the falling part 98304 - 2P/N; a
    // nonzero remainder moves the truncated result one step toward zero.
    always_comb begin
        at_fall   = (r_q > FALL_Q) || ((r_q == FALL_Q) && (r_r >= FALL_R));
        at_flat   = (r_q > FLAT_Q) || ((r_q == FLAT_Q) && (r_r >= FLAT_R));
        frac_nz   = r_r != '0;
        q_s       = signed'({2'b00, r_q});
        rise      = q_s - HALF_SCALE + V_W'((q_s < HALF_SCALE) && frac_nz);
        fall_base = FALL_OFS - q_s;
        fall      = fall_base - V_W'((fall_base > 0) && frac_nz);
        if (ODD_SIZE && at_flat && !at_fall) begin
            level = V_W'(FLAT_LEVEL);
        end else if (at_fall) begin
            level = fall;
        end else begin
            level = rise;
        end
        if (level > SAT_HI) begin
            o_sample = SMP_W'(SAT_HI);
        end else if (level < SAT_LO) begin
            o_sample = SMP_W'(SAT_LO);
        end else begin
            o_sample = level[SMP_W-1:0];
        end
    end

    assign o_busy = inc.busy;

    a_rem_below_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_r} < N_VAL)
        else $error("lane phase remainder reached the table size");

endmodule

/* sv/stereo_triangle_dds.sv */
// ----------------------------------------------------------------------------
// Stereo triangle DDS
// Two-channel triangle-wave synthesizer with linear interpolation.
// ----------------------------------------------------------------------------
// Each accepted tick request advances the left and right phase accumulators
// by their programmed Q8.16 increments and presents the resulting pair of
// signed 16-bit samples from the output register after the lane phase
// registers; a skid register holds one more pair while the output waits. A
// new tick is taken every cycle unless a divider is busy or the lane stage
// and skid register are both full. A write to an increment register starts
// that lane's divider by the table size, a reciprocal multiplication
// (quotient, then remainder); meanwhile no tick or register write is taken.
module stereo_triangle_dds import stdds_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    stdds_smp_in_if.sink    i_smp,
    stdds_smp_out_if.source o_smp,
    stdds_cfg_if.sink       i_cfg
);

    typedef struct packed {
        logic signed [SMP_W-1:0] left;
        logic signed [SMP_W-1:0] right;
        logic                    done;
    } t_result;

    logic busy_l;
    logic busy_r;
    logic any_busy;
    logic smp_acc;
    logic cfg_acc;
    logic move;
    logic out_take;

    t_lane_ctl               ctl_l;
    t_lane_ctl               ctl_r;
    logic signed [SMP_W-1:0] smp_l;
    logic signed [SMP_W-1:0] smp_r;

    logic    r_v1;
    logic    r_last1;
    logic    r_m_vld;
    logic    r_s_vld;
    t_result r_main;
    t_result r_skid;
    t_result res_new;

    assign any_busy    = busy_l | busy_r;
    assign i_cfg.ready = !any_busy;
    assign i_smp.ready = !any_busy && (!r_v1 || !r_s_vld);
    assign smp_acc     = i_smp.valid && i_smp.ready;
    assign cfg_acc     = i_cfg.valid && i_cfg.ready;
    assign move        = r_v1 && !r_s_vld;
    assign out_take    = r_m_vld && o_smp.ready;

    assign ctl_l = '{step: smp_acc, restart: i_smp.restart,
                     cfg_wr: cfg_acc && (i_cfg.index == REG_LEFT_INC),
                     cfg_data: i_cfg.data};
    assign ctl_r = '{step: smp_acc, restart: i_smp.restart,
                     cfg_wr: cfg_acc && (i_cfg.index == REG_RIGHT_INC),
                     cfg_data: i_cfg.data};

    stdds_lane u_lane_l (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl_l),
        .o_busy   (busy_l),
        .o_sample (smp_l)
    );

    stdds_lane u_lane_r (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl_r),
        .o_busy   (busy_r),
        .o_sample (smp_r)
    );

    assign res_new = '{left: smp_l, right: smp_r, done: r_last1};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_m_vld <= 1'b0;
            r_s_vld <= 1'b0;
        end else begin
            if (smp_acc) begin
                r_v1 <= 1'b1;
            end else if (move) begin
                r_v1 <= 1'b0;
            end
            if (out_take) begin
                if (r_s_vld) begin
                    r_s_vld <= 1'b0;
                end else begin
                    r_m_vld <= move;
                end
            end else if (!r_m_vld) begin
                r_m_vld <= move;
            end else if (move) begin
                r_s_vld <= 1'b1;
            end
        end
    end

    // The lane states are the first stage; the pair is merged here into the
    // output register, or into the skid register when the output is held.
    always_ff @(posedge i_clk) begin
        if (smp_acc) begin
            r_last1 <= i_smp.block_last;
        end
        if (out_take) begin
            if (r_s_vld) begin
                r_main <= r_skid;
            end else if (move) begin
                r_main <= res_new;
            end
        end else if (!r_m_vld) begin
            if (move) begin
                r_main <= res_new;
            end
        end else if (move) begin
            r_skid <= res_new;
        end
    end

    assign o_smp.valid        = r_m_vld;
    assign o_smp.left_sample  = r_main.left;
    assign o_smp.right_sample = r_main.right;
    assign o_smp.buffer_done  = r_main.done;

    a_skid_needs_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s_vld |-> r_m_vld)
        else $error("skid register holds a pair while the output register is empty");

    a_move_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        move |=> r_m_vld)
        else $error("pair left the lane stage but no result is presented");

    a_skid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s_vld && !out_take) |=> (r_s_vld && $stable(r_skid)))
        else $error("skid register changed while the output was held");

    a_write_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cfg_acc && ((i_cfg.index == REG_LEFT_INC) || (i_cfg.index == REG_RIGHT_INC)))
        |=> any_busy)
        else $error("increment write did not start the divider");

endmodule

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// Stereo triangle DDS testbench
// Drives sample tick requests and increment register writes into the
// synthesizer, predicts each left/right sample pair from its own copy of the
// phase accumulators, and compares every result in order.
// ----------------------------------------------------------------------------
module tb_top;
    import stdds_pkg::*;

    localparam longint PHASE_SPAN   = longint'(TABLE_ENTRIES) * 65536;
    localparam int     STALL_LIMIT  = 4000;
    localparam int     LONG_HOLD    = 400;
    localparam int     REPORT_LIMIT = 10;

    // Indexes that no register answers to.
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = '1;

    typedef enum int {SINK_OPEN, SINK_RANDOM, SINK_PATTERN} sink_mode_t;

    typedef struct {
        logic signed [SMP_W-1:0] left_sample;
        logic signed [SMP_W-1:0] right_sample;
        logic                    buffer_done;
    } sample_pair_t;

    logic i_clk;
    logic i_rst_n;

    stdds_smp_in_if  smp_in ();
    stdds_smp_out_if smp_out ();
    stdds_cfg_if     cfg ();

    stereo_triangle_dds dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_smp   (smp_in),
        .o_smp   (smp_out),
        .i_cfg   (cfg)
    );

    // Predictor state.
    logic [INC_W-1:0] left_step;
    logic [INC_W-1:0] right_step;
    longint           left_acc;
    longint           right_acc;
    sample_pair_t     expected_pairs[$];

    int  mismatches;
    bit  gaps_on;
    int  burst_left;
    int  hold_requests;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Triangle prediction
    // ------------------------------------------------------------------------
    function automatic longint triangle_point(input longint entry);
        longint n;
        n = longint'(TABLE_ENTRIES);
        if (entry >= n) begin
            entry = 0;
        end
        if (2 * entry < n) begin
            return -32768 * n + 131072 * entry;
        end
        return 98304 * n - 131072 * entry;
    endfunction

    function automatic logic signed [SMP_W-1:0] triangle_level(input longint acc);
        longint entry;
        longint frac;
        longint lo;
        longint hi;
        longint num;
        longint q;
        entry = acc >> 16;
        frac  = acc & 65535;
        lo    = triangle_point(entry);
        hi    = triangle_point(entry + 1);
        num   = lo * 65536 + (hi - lo) * frac;
        q     = num / PHASE_SPAN;
        if (q > 32767) begin
            q = 32767;
        end
        if (q < -32768) begin
            q = -32768;
        end
        return SMP_W'(q);
    endfunction

    function automatic sample_pair_t next_sample_pair(input logic restart, input logic last);
        sample_pair_t pair;
        if (restart) begin
            left_acc  = 0;
            right_acc = 0;
        end
        left_acc  = (left_acc % PHASE_SPAN + longint'(left_step)) % PHASE_SPAN;
        right_acc = (right_acc % PHASE_SPAN + longint'(right_step)) % PHASE_SPAN;
        pair.left_sample  = triangle_level(left_acc);
        pair.right_sample = triangle_level(right_acc);
        pair.buffer_done  = last;
        return pair;
    endfunction

    // ------------------------------------------------------------------------
    // Request drivers
    // ------------------------------------------------------------------------
    task automatic send_tick(input logic restart, input logic last);
        smp_in.valid      <= 1'b1;
        smp_in.restart    <= restart;
        smp_in.block_last <= last;
        do @(posedge i_clk); while (!smp_in.ready);
        expected_pairs.push_back(next_sample_pair(restart, last));
        if (gaps_on) begin
            if (burst_left > 0) begin
                burst_left--;
            end
            if (burst_left == 0) begin
                smp_in.valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
                burst_left = $urandom_range(1, 40);
            end
        end
    endtask

    task automatic stop_ticks();
        smp_in.valid <= 1'b0;
    endtask

    task automatic wait_drain();
        while (expected_pairs.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Registers are written only with the pipeline empty.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [INC_W-1:0] data);
        wait_drain();
        repeat (4) @(posedge i_clk);
        cfg.valid <= 1'b1;
        cfg.index <= index;
        cfg.data  <= data;
        do @(posedge i_clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
        if (index == REG_LEFT_INC) begin
            left_step = data;
        end else if (index == REG_RIGHT_INC) begin
            right_step = data;
        end
    endtask

    task automatic set_steps(input logic [INC_W-1:0] left, input logic [INC_W-1:0] right);
        write_reg(REG_LEFT_INC, left);
        write_reg(REG_RIGHT_INC, right);
    endtask

    function automatic logic [INC_W-1:0] pick_step();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return INC_W'($urandom_range(1, 24'h03FFFF));
            default: return INC_W'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_reset_state();
        gaps_on = 1'b0;
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b1);
        stop_ticks();
    endtask

    task automatic test_directed_points();
        gaps_on = 1'b0;
        // One entry per sample on the left, the largest step on the right.
        set_steps(24'h010000, '1);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        stop_ticks();
        // The left lands on the peak, which has to saturate.
        set_steps(24'h800000, 24'h7F8000);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        stop_ticks();
        // The last entry interpolates back toward the first point.
        set_steps(24'hFF8000, 24'hFF0000);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);
        stop_ticks();
        // Writes to unmapped indexes must leave both steps alone.
        write_reg(REG_UNMAPPED_LO, 24'h123456);
        write_reg(REG_UNMAPPED_HI, 24'hABCDEF);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b0);
        stop_ticks();
        set_steps('0, 24'h000001);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        stop_ticks();
    endtask

    task automatic test_random_streams(input int phases, input int ticks);
        for (int p = 0; p < phases; p++) begin
            if (p == 0) begin
                set_steps('1, '0);
            end else begin
                set_steps(pick_step(), pick_step());
            end
            gaps_on    = ($urandom_range(0, 3) != 0);
            burst_left = $urandom_range(1, 40);
            for (int t = 0; t < ticks; t++) begin
                send_tick($urandom_range(0, 49) == 0, $urandom_range(0, 15) == 0);
            end
            stop_ticks();
        end
    endtask

    task automatic test_backpressure();
        set_steps(pick_step(), pick_step());
        gaps_on = 1'b0;
        hold_requests++;
        for (int t = 0; t < 80; t++) begin
            send_tick($urandom_range(0, 49) == 0, $urandom_range(0, 15) == 0);
        end
        stop_ticks();
        wait_drain();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n           <= 1'b0;
        smp_in.valid      <= 1'b0;
        smp_in.restart    <= 1'b0;
        smp_in.block_last <= 1'b0;
        cfg.valid         <= 1'b0;
        cfg.index         <= '0;
        cfg.data          <= '0;
        left_step     = '0;
        right_step    = '0;
        left_acc      = 0;
        right_acc     = 0;
        mismatches    = 0;
        gaps_on       = 1'b0;
        burst_left    = 1;
        hold_requests = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_directed_points();
        test_random_streams(4, 250);
        test_backpressure();
        test_random_streams(4, 250);

        wait_drain();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side: stall pattern and checker
    // ------------------------------------------------------------------------
    initial begin
        sink_mode_t sink_mode;
        int         mode_left;
        int         hold_left;
        int         hold_seen;
        int         beat;
        sink_mode = SINK_OPEN;
        mode_left = 0;
        hold_left = 0;
        hold_seen = 0;
        beat      = 0;
        smp_out.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_seen != hold_requests) begin
                hold_seen = hold_requests;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                smp_out.ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    sink_mode = sink_mode_t'($urandom_range(0, 2));
                    mode_left = $urandom_range(32, 256);
                end
                mode_left--;
                beat++;
                case (sink_mode)
                    SINK_OPEN:    smp_out.ready <= 1'b1;
                    SINK_RANDOM:  smp_out.ready <= ($urandom_range(0, 99) < 60);
                    SINK_PATTERN: smp_out.ready <= ((beat % 7) >= 3);
                    default:      smp_out.ready <= 1'b1;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        sample_pair_t want;
        if (i_rst_n && smp_out.valid && smp_out.ready) begin
            if (expected_pairs.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("Unexpected sample pair: left %0d right %0d done %0b",
                             smp_out.left_sample, smp_out.right_sample, smp_out.buffer_done);
                end
            end else begin
                want = expected_pairs.pop_front();
                if (smp_out.left_sample !== want.left_sample
                        || smp_out.right_sample !== want.right_sample
                        || smp_out.buffer_done !== want.buffer_done) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("Sample pair mismatch: expected left %0d right %0d done %0b,",
                                 want.left_sample, want.right_sample, want.buffer_done,
                                 " got left %0d right %0d done %0b",
                                 smp_out.left_sample, smp_out.right_sample,
                                 smp_out.buffer_done);
                    end
                end
            end
        end
    end

    // Ends the run when no request moves on any channel for too long.
    initial begin
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((smp_in.valid && smp_in.ready) || (smp_out.valid && smp_out.ready)
                    || (cfg.valid && cfg.ready)) begin
                idle = 0;
            end else begin
                idle++;
            end
        end
        $display("Timeout: no request accepted for %0d cycles", STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* sim.f */
sv/stdds_pkg.sv
sv/stdds_smp_in_if.sv
sv/stdds_smp_out_if.sv
sv/stdds_cfg_if.sv
sv/stdds_inc_div.sv
sv/stdds_lane.sv
sv/stereo_triangle_dds.sv
verif/tb_top.sv
